// File: rtl/core/ceia_pkg.sv
// Shared types and constants of the checked 64-bit expression ALU.
package ceia_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned ProdWidth = 2 * DataWidth;
   localparam int unsigned CellCount = DataWidth;
   localparam int unsigned OpWidth   = 5;

   localparam logic [DataWidth-1:0] SignBit  = {1'b1, {(DataWidth-1){1'b0}}};
   localparam logic [DataWidth-1:0] SmaxBits = {1'b0, {(DataWidth-1){1'b1}}};

   typedef enum logic [OpWidth-1:0] {
      OP_ADD    = 5'd0,
      OP_SUB    = 5'd1,
      OP_MUL    = 5'd2,
      OP_DIV    = 5'd3,
      OP_MOD    = 5'd4,
      OP_SHL    = 5'd5,
      OP_SHR    = 5'd6,
      OP_LT     = 5'd7,
      OP_GT     = 5'd8,
      OP_LE     = 5'd9,
      OP_GE     = 5'd10,
      OP_EQ     = 5'd11,
      OP_NE     = 5'd12,
      OP_AND    = 5'd13,
      OP_XOR    = 5'd14,
      OP_OR     = 5'd15,
      OP_PLUS   = 5'd16,
      OP_NEG    = 5'd17,
      OP_LNOT   = 5'd18,
      OP_BITNOT = 5'd19,
      OP_LAND   = 5'd20,
      OP_LOR    = 5'd21
   } op_type;

   // Which long operation the cell chain finishes for this transaction
   typedef enum logic [1:0] {
      ARITH_NONE,
      ARITH_MUL,
      ARITH_DIV,
      ARITH_MOD
   } arith_type;

   // One transaction as it travels down the cell chain
   typedef struct packed {
      arith_type              arith;
      logic                   chk_ovf;    // signed multiply: range check at the end
      logic                   neg_res;    // negate the magnitude result
      logic                   res_uns;
      logic                   simple_err;
      logic [DataWidth-1:0]   simple_val;
      logic [DataWidth-1:0]   ma;         // multiplicand / dividend magnitude
      logic [DataWidth-1:0]   mb;         // multiplier / divisor magnitude
      logic [DataWidth-1:0]   rem;
      logic [DataWidth-1:0]   quo;
      logic [ProdWidth-1:0]   prod;
   } stage_type;

endpackage

// File: rtl/core/ceia_if.sv
// Valid/ready channel interfaces for requests and responses.
interface ceia_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  req_type;
   logic [63:0] left_value;
   logic        left_is_unsigned;
   logic [63:0] right_value;
   logic        right_is_unsigned;
   logic        evaluate;

   modport source (output valid, req_type, left_value, left_is_unsigned, right_value,
                   right_is_unsigned, evaluate, input ready);
   modport sink   (input valid, req_type, left_value, left_is_unsigned, right_value,
                   right_is_unsigned, evaluate, output ready);
endinterface

interface ceia_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_value;
   logic        result_is_unsigned;
   logic        error;

   modport source (output valid, result_value, result_is_unsigned, error, input ready);
   modport sink   (input valid, result_value, result_is_unsigned, error, output ready);
endinterface

// File: rtl/core/checked_int64_expression_alu.sv
// Top level: checked 64-bit expression ALU built as a decode stage and a chain of cells.
//
//   channel | direction | payload
//   req     | in        | req_type, left/right value and unsigned flags, evaluate
//   rsp     | out       | result_value, result_is_unsigned, error
//
// One transaction per cycle while the sink is ready. An accepted request enters the
// decode register, then passes through the 64 cells and the output register; each cell
// retires one quotient bit and one multiplier bit.
// Synchronous reset clears only valid bits. The whole pipeline stalls while a result
// waits in the output register and the sink holds ready low.
module checked_int64_expression_alu import ceia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ceia_req_if.sink     req_port,
   ceia_rsp_if.source   rsp_port
);

   logic                 advance;
   stage_type            dec_stage;
   logic                 dec_valid_ff;
   stage_type            dec_stage_ff;
   logic                 vld [0:CellCount];
   stage_type            pipe [0:CellCount];
   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] rsp_value_ff, rsp_value_in, prod_lo, lim;
   logic                 rsp_uns_ff, rsp_err_ff, rsp_err_in, mul_ovf;
   stage_type            last;

   assign advance        = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;

   ceia_decode u_decode (
      .req_type          (req_port.req_type),
      .left_value        (req_port.left_value),
      .left_is_unsigned  (req_port.left_is_unsigned),
      .right_value       (req_port.right_value),
      .right_is_unsigned (req_port.right_is_unsigned),
      .evaluate          (req_port.evaluate),
      .stage             (dec_stage)
   );

   // Decode register feeds the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (advance) begin
         dec_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) dec_stage_ff <= dec_stage;
   end

   assign vld[0]  = dec_valid_ff;
   assign pipe[0] = dec_stage_ff;

   // Cell chain
   for (genvar g = 0; g < CellCount; g++) begin : g_cell
      ceia_cell #(.Index(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vld[g]),
         .in_stage  (pipe[g]),
         .out_valid (vld[g+1]),
         .out_stage (pipe[g+1])
      );
   end

   // Final sign fixup and signed multiply range check
   always_comb begin
      last    = pipe[CellCount];
      prod_lo = last.prod[DataWidth-1:0];
      lim     = last.neg_res ? SignBit : SmaxBits;
      mul_ovf = last.chk_ovf && ((|last.prod[ProdWidth-1:DataWidth]) || (prod_lo > lim));
      rsp_err_in   = last.simple_err;
      rsp_value_in = last.simple_val;
      unique case (last.arith)
         ARITH_MUL: begin
            rsp_err_in   = mul_ovf;
            rsp_value_in = last.neg_res ? (~prod_lo + 1'b1) : prod_lo;
         end
         ARITH_DIV: rsp_value_in = last.neg_res ? (~last.quo + 1'b1) : last.quo;
         ARITH_MOD: rsp_value_in = last.neg_res ? (~last.rem + 1'b1) : last.rem;
         default:   rsp_value_in = last.simple_val;
      endcase
      if (rsp_err_in) rsp_value_in = '0;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld[CellCount];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= rsp_value_in;
         rsp_uns_ff   <= last.res_uns;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   assign rsp_port.valid              = rsp_valid_ff;
   assign rsp_port.result_value       = rsp_value_ff;
   assign rsp_port.result_is_unsigned = rsp_uns_ff;
   assign rsp_port.error              = rsp_err_ff;

   // An error result never carries a value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_value_ff == '0)
      else $error("error response with nonzero value");

   // An accepted transaction enters the decode register
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready |=> dec_valid_ff)
      else $error("accepted transaction lost at decode");

   // A transaction leaving the last cell reaches the output register
   a_exit: assert property (@(posedge clock) disable iff (reset)
      vld[CellCount] && advance |=> rsp_valid_ff)
      else $error("transaction lost at chain output");

endmodule

// File: rtl/core/ceia_decode.sv
// Operation decode: simple ops, error checks and setup for the cell chain.
module ceia_decode import ceia_pkg::*; (
   input  logic [OpWidth-1:0]   req_type,
   input  logic [DataWidth-1:0] left_value,
   input  logic                 left_is_unsigned,
   input  logic [DataWidth-1:0] right_value,
   input  logic                 right_is_unsigned,
   input  logic                 evaluate,
   output stage_type            stage
);

   logic                 cu;
   logic [DataWidth-1:0] a, b, mag_a, mag_b, sum, dif, shr_v, shl_lim;
   logic [5:0]           cnt;
   logic                 big_cnt, lt, gt, add_ovf, sub_ovf;

   // Shared datapath pieces
   always_comb begin
      a       = left_value;
      b       = right_value;
      cu      = left_is_unsigned | right_is_unsigned;
      mag_a   = a[DataWidth-1] ? (~a + 1'b1) : a;
      mag_b   = b[DataWidth-1] ? (~b + 1'b1) : b;
      sum     = a + b;
      dif     = a - b;
      add_ovf = (a[DataWidth-1] == b[DataWidth-1]) && (sum[DataWidth-1] != a[DataWidth-1]);
      sub_ovf = (a[DataWidth-1] != b[DataWidth-1]) && (dif[DataWidth-1] != a[DataWidth-1]);
      cnt     = b[5:0];
      big_cnt = |b[DataWidth-1:6];
      shr_v   = left_is_unsigned ? (a >> cnt) : DataWidth'($signed(a) >>> cnt);
      shl_lim = SmaxBits >> cnt;
      lt      = cu ? (a < b) : ($signed(a) < $signed(b));
      gt      = cu ? (b < a) : ($signed(b) < $signed(a));
   end

   // Per-operation result and chain setup
   always_comb begin
      stage       = '0;
      stage.arith = ARITH_NONE;
      unique case (op_type'(req_type))
         OP_ADD, OP_SUB: begin
            stage.res_uns = cu;
            if (evaluate) begin
               stage.simple_val = (op_type'(req_type) == OP_ADD) ? sum : dif;
               stage.simple_err = !cu &&
                  ((op_type'(req_type) == OP_ADD) ? add_ovf : sub_ovf);
            end
         end
         OP_MUL, OP_DIV, OP_MOD: begin
            stage.res_uns = cu;
            if (evaluate) begin
               if ((op_type'(req_type) != OP_MUL) &&
                   ((b == '0) || (!cu && a == SignBit && b == '1))) begin
                  stage.simple_err = 1'b1;
               end else begin
                  stage.ma = cu ? a : mag_a;
                  stage.mb = cu ? b : mag_b;
                  unique case (op_type'(req_type))
                     OP_MUL: begin
                        stage.arith   = ARITH_MUL;
                        stage.chk_ovf = !cu;
                        stage.neg_res = !cu && (a[DataWidth-1] ^ b[DataWidth-1]);
                     end
                     OP_DIV: begin
                        stage.arith   = ARITH_DIV;
                        stage.neg_res = !cu && (a[DataWidth-1] ^ b[DataWidth-1]);
                     end
                     default: begin
                        stage.arith   = ARITH_MOD;
                        stage.neg_res = !cu && a[DataWidth-1];
                     end
                  endcase
               end
            end
         end
         OP_SHL, OP_SHR: begin
            stage.res_uns = left_is_unsigned;
            if (evaluate) begin
               if (big_cnt) begin
                  stage.simple_err = 1'b1;
               end else if (op_type'(req_type) == OP_SHR) begin
                  stage.simple_val = shr_v;
               end else if (!left_is_unsigned && (a[DataWidth-1] || a > shl_lim)) begin
                  stage.simple_err = 1'b1;
               end else begin
                  stage.simple_val = a << cnt;
               end
            end
         end
         OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE: begin
            if (evaluate) begin
               unique case (op_type'(req_type))
                  OP_LT:   stage.simple_val[0] = lt;
                  OP_GT:   stage.simple_val[0] = gt;
                  OP_LE:   stage.simple_val[0] = !gt;
                  OP_GE:   stage.simple_val[0] = !lt;
                  OP_EQ:   stage.simple_val[0] = (a == b);
                  default: stage.simple_val[0] = (a != b);
               endcase
            end
         end
         OP_AND, OP_XOR, OP_OR: begin
            stage.res_uns = cu;
            if (evaluate) begin
               unique case (op_type'(req_type))
                  OP_AND:  stage.simple_val = a & b;
                  OP_XOR:  stage.simple_val = a ^ b;
                  default: stage.simple_val = a | b;
               endcase
            end
         end
         OP_PLUS, OP_BITNOT: begin
            stage.res_uns = left_is_unsigned;
            if (evaluate) begin
               stage.simple_val = (op_type'(req_type) == OP_PLUS) ? a : ~a;
            end
         end
         OP_NEG: begin
            stage.res_uns = left_is_unsigned;
            if (evaluate) begin
               if (!left_is_unsigned && a == SignBit) stage.simple_err = 1'b1;
               else stage.simple_val = ~a + 1'b1;
            end
         end
         OP_LNOT: begin
            if (evaluate) stage.simple_val[0] = (a == '0);
         end
         OP_LAND: begin
            stage.simple_val[0] = evaluate && (a != '0) && (b != '0);
         end
         OP_LOR: begin
            stage.simple_val[0] = evaluate && ((a != '0) || (b != '0));
         end
         default: begin
            // unknown operation code
            stage.simple_err = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/core/ceia_cell.sv
// One chain cell: one restoring divide step and one shift-add multiply step.
module ceia_cell import ceia_pkg::*; #(
   parameter int unsigned Index = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  stage_type in_stage,
   output logic      out_valid,
   output stage_type out_stage
);

   localparam int unsigned DivBit = DataWidth - 1 - Index;

   logic                 valid_ff, valid_in;
   stage_type            stage_ff, stage_in;
   logic [DataWidth:0]   trial;
   logic [ProdWidth-1:0] addend;

   // Divide step on dividend bit DivBit, multiply step on multiplier bit Index
   always_comb begin
      stage_in = in_stage;
      trial    = {in_stage.rem, in_stage.ma[DivBit]};
      if (trial >= {1'b0, in_stage.mb}) begin
         stage_in.rem          = DataWidth'(trial - {1'b0, in_stage.mb});
         stage_in.quo[DivBit]  = 1'b1;
      end else begin
         stage_in.rem          = trial[DataWidth-1:0];
      end
      addend = {{DataWidth{1'b0}}, in_stage.ma} << Index;
      if (in_stage.mb[Index]) stage_in.prod = in_stage.prod + addend;
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// File: sim/checked_int64_expression_alu_tb.sv
// Self-checking testbench for the checked 64-bit expression ALU.
`timescale 1ns / 1ps

module checked_int64_expression_alu_tb;
   import ceia_pkg::*;

   localparam int unsigned PipeLatency = 65;
   localparam int unsigned StallLimit  = 20000;

   typedef struct packed {
      logic [63:0] value;
      logic        is_uns;
      logic        err;
   } alu_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ceia_req_if req_bus ();
   ceia_rsp_if rsp_bus ();

   checked_int64_expression_alu dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus.sink),
      .rsp_port (rsp_bus.source)
   );

   alu_result_type expected_results[$];
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;
   bit          send_gaps      = 1'b1;
   bit          sink_stalls    = 1'b1;

   initial begin
      forever #10 clock = ~clock;
   end

   // Expected result of one operation
   function automatic alu_result_type predict_alu(logic [4:0] op, logic [63:0] a, logic au,
                                                  logic [63:0] b, logic bu, logic ev);
      alu_result_type r;
      logic        cu;
      logic        lt, gt, negr;
      logic [63:0] ma, mb, lim, q;
      cu = au | bu;
      r  = '0;
      if (op > OP_LOR) begin
         r.err = 1'b1;
         return r;
      end
      case (op_type'(op))
         OP_PLUS, OP_NEG, OP_BITNOT: begin
            r.is_uns = au;
            if (ev) begin
               if (op == OP_PLUS) r.value = a;
               else if (op == OP_BITNOT) r.value = ~a;
               else if (!au && a == SignBit) r.err = 1'b1;
               else r.value = -a;
            end
         end
         OP_LNOT: r.value = ev ? 64'(a == 0) : '0;
         OP_LAND: r.value = 64'(ev && a != 0 && b != 0);
         OP_LOR:  r.value = 64'(ev && (a != 0 || b != 0));
         OP_SHL, OP_SHR: begin
            r.is_uns = au;
            if (ev) begin
               if (b >= 64) r.err = 1'b1;
               else if (op == OP_SHR)
                  r.value = au ? a >> b[5:0] : 64'($signed(a) >>> b[5:0]);
               else if (au) r.value = a << b[5:0];
               else if (a[63] || a > (SmaxBits >> b[5:0])) r.err = 1'b1;
               else r.value = a << b[5:0];
            end
         end
         OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE: begin
            lt = cu ? (a < b) : ($signed(a) < $signed(b));
            gt = cu ? (b < a) : ($signed(b) < $signed(a));
            if (ev) begin
               case (op_type'(op))
                  OP_LT:   r.value = 64'(lt);
                  OP_GT:   r.value = 64'(gt);
                  OP_LE:   r.value = 64'(!gt);
                  OP_GE:   r.value = 64'(!lt);
                  OP_EQ:   r.value = 64'(a == b);
                  default: r.value = 64'(a != b);
               endcase
            end
         end
         default: begin
            r.is_uns = cu;
            if (!ev) return r;
            if (op == OP_AND) r.value = a & b;
            else if (op == OP_XOR) r.value = a ^ b;
            else if (op == OP_OR) r.value = a | b;
            else if (op == OP_ADD) begin
               r.value = a + b;
               r.err = !cu && (a[63] == b[63]) && (r.value[63] != a[63]);
            end else if (op == OP_SUB) begin
               r.value = a - b;
               r.err = !cu && (a[63] != b[63]) && (r.value[63] != a[63]);
            end else if (cu) begin
               if (op == OP_MUL) r.value = a * b;
               else if (b == 0) r.err = 1'b1;
               else r.value = (op == OP_DIV) ? a / b : a % b;
            end else begin
               ma = a[63] ? -a : a;
               mb = b[63] ? -b : b;
               negr = a[63] ^ b[63];
               if (op == OP_MUL) begin
                  if (a != 0 && b != 0) begin
                     lim = negr ? SignBit : SmaxBits;
                     if (ma > lim / mb) r.err = 1'b1;
                     else r.value = negr ? -(ma * mb) : ma * mb;
                  end
               end else if (b == 0 || (a == SignBit && b == '1)) r.err = 1'b1;
               else if (op == OP_DIV) begin
                  q = ma / mb;
                  r.value = negr ? -q : q;
               end else begin
                  q = ma % mb;
                  r.value = a[63] ? -q : q;
               end
            end
         end
      endcase
      if (r.err) r.value = '0;
      return r;
   endfunction

   // Send one transaction, with an optional random gap first
   task automatic send_op(logic [4:0] op, logic [63:0] a, logic au, logic [63:0] b,
                          logic bu, logic ev);
      int unsigned gap;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.req_type          <= op;
      req_bus.left_value        <= a;
      req_bus.left_is_unsigned  <= au;
      req_bus.right_value       <= b;
      req_bus.right_is_unsigned <= bu;
      req_bus.evaluate          <= ev;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results = {expected_results, predict_alu(op, a, au, b, bu, ev)};
   endtask

   task automatic release_bus();
      req_bus.valid <= 1'b0;
   endtask

   // Random operand biased toward edge values
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return SignBit;
         3: return SmaxBits;
         4: return 64'($urandom_range(0, 70));
         5: return -64'($urandom_range(1, 70));
         6: return {32'h0, $urandom()};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Sink side: random stalls, compare each transaction against the oldest prediction
   always @(posedge clock) begin
      alu_result_type exp_r;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result %h", rsp_bus.result_value);
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r !== {rsp_bus.result_value, rsp_bus.result_is_unsigned, rsp_bus.error})
               begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected value %h uns %b err %b, got %h %b %b",
                              exp_r.value, exp_r.is_uns, exp_r.err, rsp_bus.result_value,
                              rsp_bus.result_is_unsigned, rsp_bus.error);
               end
            end
         end
         rsp_bus.ready <= !sink_stalls || ($urandom_range(0, 4) != 0);
      end
   end

   // Watchdog on cycles with no accepted transaction
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("checked_int64_expression_alu_tb failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(OP_ADD, SmaxBits, 1'b0, 64'd1, 1'b0, 1'b1);
      send_op(OP_ADD, '1, 1'b1, 64'd1, 1'b0, 1'b1);
      send_op(OP_SUB, SignBit, 1'b0, 64'd1, 1'b0, 1'b1);
      send_op(OP_MUL, SignBit, 1'b0, 64'd1, 1'b0, 1'b1);
      send_op(OP_MUL, SignBit, 1'b0, '1, 1'b0, 1'b1);
      send_op(OP_MUL, 64'h1_0000_0000, 1'b0, 64'h8000_0000, 1'b0, 1'b1);
      send_op(OP_DIV, SignBit, 1'b0, '1, 1'b0, 1'b1);
      send_op(OP_DIV, -64'd7, 1'b0, 64'd2, 1'b0, 1'b1);
      send_op(OP_MOD, -64'd7, 1'b0, 64'd2, 1'b0, 1'b1);
      send_op(OP_MOD, 64'd5, 1'b1, 64'd0, 1'b0, 1'b1);
      send_op(OP_SHL, 64'd1, 1'b0, 64'd62, 1'b0, 1'b1);
      send_op(OP_SHL, 64'd1, 1'b0, 64'd63, 1'b0, 1'b1);
      send_op(OP_SHL, '1, 1'b0, 64'd0, 1'b0, 1'b1);
      send_op(OP_SHR, SignBit, 1'b0, 64'd63, 1'b0, 1'b1);
      send_op(OP_SHR, SignBit, 1'b0, '1, 1'b0, 1'b1);
      send_op(OP_SHR, SignBit, 1'b1, 64'd64, 1'b1, 1'b1);
      send_op(OP_LT, '1, 1'b0, 64'd0, 1'b1, 1'b1);
      send_op(OP_GE, '1, 1'b0, 64'd0, 1'b0, 1'b1);
      send_op(OP_NEG, SignBit, 1'b0, '0, 1'b0, 1'b1);
      send_op(OP_LNOT, '0, 1'b1, '0, 1'b0, 1'b1);
      send_op(OP_BITNOT, '0, 1'b1, '0, 1'b0, 1'b1);
      send_op(OP_LAND, 64'd3, 1'b0, 64'd9, 1'b0, 1'b0);
      send_op(OP_LOR, '0, 1'b0, 64'd9, 1'b0, 1'b1);
      send_op(OP_ADD, SmaxBits, 1'b0, 64'd1, 1'b1, 1'b0);
      send_op(5'd31, '1, 1'b1, '1, 1'b1, 1'b1);
   endtask

   task automatic test_random(int unsigned count);
      logic [4:0] op;
      for (int unsigned i = 0; i < count; i++) begin
         op = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(22, 31))
                                           : 5'($urandom_range(0, 21));
         send_op(op, pick_operand(), 1'($urandom()),
                 ((op == OP_SHL || op == OP_SHR) && $urandom_range(0, 3) != 0)
                    ? 64'($urandom_range(0, 64)) : pick_operand(),
                 1'($urandom()), $urandom_range(0, 7) != 0);
      end
   endtask

   initial begin
      req_bus.valid             <= 1'b0;
      req_bus.req_type          <= '0;
      req_bus.left_value        <= '0;
      req_bus.left_is_unsigned  <= 1'b0;
      req_bus.right_value       <= '0;
      req_bus.right_is_unsigned <= 1'b0;
      req_bus.evaluate          <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      release_bus();
      wait_drained();
      test_random(500);
      release_bus();
      wait_drained();
      test_random(500);
      // no idling on either side at the end
      send_gaps   = 1'b0;
      sink_stalls = 1'b0;
      test_random(100);
      release_bus();
      wait_drained();
      repeat (PipeLatency + 4) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("checked_int64_expression_alu_tb passed");
      end else begin
         $display("checked_int64_expression_alu_tb failed");
      end
      $finish;
   end

endmodule
